@@ hw/rtl/mcsp_pkg.sv @@
// Package for the mip chain shelf packer: sizes, codes, sequencer state and the
// cursor and tile structures passed between the packer modules.
// No dependencies.
package mcsp_pkg;

    localparam int MAX_MIPS  = 16;
    localparam int MAX_SIDE  = 4094;
    localparam int MIN_PAGE  = 256;
    localparam int MAX_PAGE  = 4096;
    localparam int BORDER    = 2;

    localparam int PAGE_W    = 13;
    localparam int LIMIT_W   = 12;
    localparam int SIDE_W    = 13;
    localparam int TILE_W    = 12;
    localparam int LAYER_W   = 11;
    localparam int TEXNUM_W  = 16;
    localparam int MIP_W     = 4;
    localparam int LEVELS_W  = 8;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAGE_SIZE  = 2'd0,
        REG_MAX_LAYERS = 2'd1
    } mcsp_reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_SIDE_LARGE = 2'd1,
        ST_PAGE_LARGE = 2'd2,
        ST_LAYER_LIM  = 2'd3
    } mcsp_status_t;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_PLACE = 1'b1
    } mcsp_action_t;

    typedef enum logic [2:0] {
        SEQ_IDLE   = 3'b001,
        SEQ_REJECT = 3'b010,
        SEQ_RUN    = 3'b100
    } mcsp_seq_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  x;
        logic [PAGE_W-1:0]  y;
        logic [PAGE_W-1:0]  rh;
        logic [LAYER_W-1:0] layer;
    } mcsp_cursor_t;

    typedef struct packed {
        logic [TILE_W-1:0]  tile_x;
        logic [TILE_W-1:0]  tile_y;
        logic [LAYER_W-1:0] layer;
        logic               flag;
        mcsp_cursor_t       next;
    } mcsp_tile_t;

endpackage

@@ hw/rtl/mcsp_in_if.sv @@
// Input channel of the packer: one texture word per handshake.
// Depends on mcsp_pkg.
interface mcsp_in_if import mcsp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                action;
    logic [SIDE_W-1:0]   tex_width;
    logic [SIDE_W-1:0]   tex_height;
    logic [LEVELS_W-1:0] mip_levels;

    modport source (output valid, action, tex_width, tex_height, mip_levels, input ready);
    modport sink   (input valid, action, tex_width, tex_height, mip_levels, output ready);
endinterface

@@ hw/rtl/mcsp_out_if.sv @@
// Output channel of the packer: one tile word per handshake.
// Depends on mcsp_pkg.
interface mcsp_out_if import mcsp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TEXNUM_W-1:0] texture_number;
    logic [MIP_W-1:0]    mip;
    logic [TILE_W-1:0]   tile_x;
    logic [TILE_W-1:0]   tile_y;
    logic [TILE_W-1:0]   tile_width;
    logic [TILE_W-1:0]   tile_height;
    logic [LAYER_W-1:0]  layer;
    logic [1:0]          status;
    logic                last;

    modport source (output valid, texture_number, mip, tile_x, tile_y, tile_width,
                    tile_height, layer, status, last, input ready);
    modport sink   (input valid, texture_number, mip, tile_x, tile_y, tile_width,
                    tile_height, layer, status, last, output ready);
endinterface

@@ hw/rtl/mcsp_cfg_if.sv @@
// Configuration write channel of the packer: register index and data.
// Depends on mcsp_pkg.
interface mcsp_cfg_if import mcsp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [PAGE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/mip_chain_shelf_packer_unit.sv @@
// Mip chain shelf packer: top level with sequencer, cursor and output register.
// First tile word goes into the output register from the RUN or REJECT state that
// follows accept, once the output is free. The input is held while a place word's
// tiles go out (up to 16, one on a reject) and while the output stalls; one shared
// placement unit. A start word gives no output and leaves the input ready.
// Reset clears cursor, texture counter, state and output valid; page 256, layer limit 256.
module mip_chain_shelf_packer_unit import mcsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mcsp_in_if.sink     texture,
    mcsp_out_if.source  tile,
    mcsp_cfg_if.sink    cfg
);

    logic [PAGE_W-1:0]   page;
    logic [LIMIT_W-1:0]  max_layers;
    mcsp_tile_t          place;
    logic [TILE_W-1:0]   cur_w;
    logic [TILE_W-1:0]   cur_h;

    mcsp_seq_t           state_reg, state_next;
    mcsp_cursor_t        cursor_reg, cursor_next;
    logic [TEXNUM_W-1:0] counter_reg, counter_next;
    logic [TEXNUM_W-1:0] texnum_reg, texnum_next;
    logic [MIP_W-1:0]    mip_reg, mip_next;
    logic [MIP_W-1:0]    count_reg, count_next;
    logic [TILE_W-1:0]   w_reg, w_next;
    logic [TILE_W-1:0]   h_reg, h_next;
    mcsp_status_t        rej_reg, rej_next;
    logic                ovalid_reg, ovalid_next;

    logic [MIP_W-1:0]    o_mip_reg, o_mip_next;
    logic [TILE_W-1:0]   o_x_reg, o_x_next;
    logic [TILE_W-1:0]   o_y_reg, o_y_next;
    logic [TILE_W-1:0]   o_w_reg, o_w_next;
    logic [TILE_W-1:0]   o_h_reg, o_h_next;
    logic [LAYER_W-1:0]  o_layer_reg, o_layer_next;
    mcsp_status_t        o_status_reg, o_status_next;
    logic                o_last_reg, o_last_next;
    logic [TEXNUM_W-1:0] o_tex_reg, o_tex_next;

    logic                accept;
    logic                slot_free;
    logic [SIDE_W-1:0]   bigger;
    logic                is_last;

    mcsp_cfg_regs u_cfg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .page       (page),
        .max_layers (max_layers)
    );

    assign cur_w = (w_reg == '0) ? TILE_W'(1) : w_reg;
    assign cur_h = (h_reg == '0) ? TILE_W'(1) : h_reg;

    mcsp_tile_unit u_tile
    (
        .cur        (cursor_reg),
        .w          (cur_w),
        .h          (cur_h),
        .page       (page),
        .max_layers (max_layers),
        .res        (place)
    );

    assign texture.ready = (state_reg == SEQ_IDLE);
    assign accept        = texture.valid && texture.ready;
    assign slot_free     = !ovalid_reg || tile.ready;
    assign bigger        = (texture.tex_width > texture.tex_height) ?
                           texture.tex_width : texture.tex_height;
    assign is_last       = (mip_reg == count_reg);

    assign tile.valid          = ovalid_reg;
    assign tile.texture_number = o_tex_reg;
    assign tile.mip            = o_mip_reg;
    assign tile.tile_x         = o_x_reg;
    assign tile.tile_y         = o_y_reg;
    assign tile.tile_width     = o_w_reg;
    assign tile.tile_height    = o_h_reg;
    assign tile.layer          = o_layer_reg;
    assign tile.status         = o_status_reg;
    assign tile.last           = o_last_reg;

    always_comb
    begin
        state_next    = state_reg;
        cursor_next   = cursor_reg;
        counter_next  = counter_reg;
        texnum_next   = texnum_reg;
        mip_next      = mip_reg;
        count_next    = count_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        rej_next      = rej_reg;
        ovalid_next   = ovalid_reg && !tile.ready;
        o_tex_next    = o_tex_reg;
        o_mip_next    = o_mip_reg;
        o_x_next      = o_x_reg;
        o_y_next      = o_y_reg;
        o_w_next      = o_w_reg;
        o_h_next      = o_h_reg;
        o_layer_next  = o_layer_reg;
        o_status_next = o_status_reg;
        o_last_next   = o_last_reg;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    if (texture.action == ACT_START)
                    begin
                        cursor_next  = '0;
                        counter_next = '0;
                    end
                    else
                    begin
                        texnum_next  = counter_reg;
                        counter_next = counter_reg + TEXNUM_W'(1);
                        w_next       = texture.tex_width[TILE_W-1:0];
                        h_next       = texture.tex_height[TILE_W-1:0];
                        mip_next     = '0;
                        count_next   = (texture.mip_levels > LEVELS_W'(MAX_MIPS - 1)) ?
                                       MIP_W'(MAX_MIPS - 1) : texture.mip_levels[MIP_W-1:0];
                        priority if (texture.tex_width > SIDE_W'(MAX_SIDE) ||
                                     texture.tex_height > SIDE_W'(MAX_SIDE))
                        begin
                            rej_next   = ST_SIDE_LARGE;
                            state_next = SEQ_REJECT;
                        end
                        else if (({1'b0, bigger} + (SIDE_W+1)'(BORDER)) > {1'b0, page})
                        begin
                            rej_next   = ST_PAGE_LARGE;
                            state_next = SEQ_REJECT;
                        end
                        else
                            state_next = SEQ_RUN;
                    end
                end
            end
            SEQ_REJECT:
            begin
                if (slot_free)
                begin
                    ovalid_next   = 1'b1;
                    o_tex_next    = texnum_reg;
                    o_mip_next    = '0;
                    o_x_next      = '0;
                    o_y_next      = '0;
                    o_w_next      = '0;
                    o_h_next      = '0;
                    o_layer_next  = cursor_reg.layer;
                    o_status_next = rej_reg;
                    o_last_next   = 1'b1;
                    state_next    = SEQ_IDLE;
                end
            end
            SEQ_RUN:
            begin
                if (slot_free)
                begin
                    ovalid_next   = 1'b1;
                    o_tex_next    = texnum_reg;
                    o_mip_next    = mip_reg;
                    o_x_next      = place.tile_x;
                    o_y_next      = place.tile_y;
                    o_w_next      = cur_w;
                    o_h_next      = cur_h;
                    o_layer_next  = place.layer;
                    o_status_next = place.flag ? ST_LAYER_LIM : ST_OK;
                    o_last_next   = place.flag || is_last;
                    w_next        = w_reg >> 1;
                    h_next        = h_reg >> 1;
                    mip_next      = mip_reg + MIP_W'(1);
                    if (!place.flag)
                        cursor_next = place.next;
                    if (place.flag || is_last)
                        state_next = SEQ_IDLE;
                end
            end
            default:
                state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SEQ_IDLE;
            cursor_reg  <= '0;
            counter_reg <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            counter_reg <= counter_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        texnum_reg   <= texnum_next;
        mip_reg      <= mip_next;
        count_reg    <= count_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        rej_reg      <= rej_next;
        o_tex_reg    <= o_tex_next;
        o_mip_reg    <= o_mip_next;
        o_x_reg      <= o_x_next;
        o_y_reg      <= o_y_next;
        o_w_reg      <= o_w_next;
        o_h_reg      <= o_h_next;
        o_layer_reg  <= o_layer_next;
        o_status_reg <= o_status_next;
        o_last_reg   <= o_last_next;
    end

endmodule

@@ hw/rtl/mcsp_cfg_regs.sv @@
// Configuration registers: page side (held already clamped) and layer limit.
// Depends on mcsp_pkg and mcsp_cfg_if.
module mcsp_cfg_regs import mcsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    mcsp_cfg_if.sink           cfg,
    output logic [PAGE_W-1:0]  page,
    output logic [LIMIT_W-1:0] max_layers
);

    logic [PAGE_W-1:0]  page_reg;
    logic [PAGE_W-1:0]  page_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;
    logic               wr;

    assign cfg.ready  = 1'b1;
    assign wr         = cfg.valid;
    assign page       = page_reg;
    assign max_layers = limit_reg;

    always_comb
    begin
        page_next  = page_reg;
        limit_next = limit_reg;
        if (wr && cfg.index == REG_PAGE_SIZE)
        begin
            priority if (cfg.data < PAGE_W'(MIN_PAGE))
                page_next = PAGE_W'(MIN_PAGE);
            else if (cfg.data > PAGE_W'(MAX_PAGE))
                page_next = PAGE_W'(MAX_PAGE);
            else
                page_next = cfg.data;
        end
        if (wr && cfg.index == REG_MAX_LAYERS)
            limit_next = cfg.data[LIMIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg  <= PAGE_W'(MIN_PAGE);
            limit_reg <= LIMIT_W'(256);
        end
        else
        begin
            page_reg  <= page_next;
            limit_reg <= limit_next;
        end
    end

endmodule

@@ hw/rtl/mcsp_tile_unit.sv @@
// Shared shelf placement unit: wraps the row, opens a layer, checks the layer
// limit and gives the advanced cursor for one tile. Depends on mcsp_pkg.
module mcsp_tile_unit import mcsp_pkg::*;
(
    input  mcsp_cursor_t        cur,
    input  logic [TILE_W-1:0]   w,
    input  logic [TILE_W-1:0]   h,
    input  logic [PAGE_W-1:0]   page,
    input  logic [LIMIT_W-1:0]  max_layers,
    output mcsp_tile_t          res
);

    logic [PAGE_W:0]    x_end;
    logic               wrap;
    logic [PAGE_W-1:0]  x1;
    logic [PAGE_W:0]    y1;
    logic [PAGE_W-1:0]  rh1;
    logic [PAGE_W+1:0]  y_end;
    logic               new_layer;
    logic [PAGE_W-1:0]  x2;
    logic [PAGE_W:0]    y2;
    logic [PAGE_W-1:0]  rh2;
    logic [LAYER_W:0]   layer2;
    logic [LAYER_W+1:0] lim;
    logic [PAGE_W-1:0]  slot_h;

    always_comb
    begin
        x_end = {1'b0, cur.x} + (PAGE_W+1)'(w) + (PAGE_W+1)'(BORDER);
        wrap  = x_end > {1'b0, page};
        x1    = wrap ? '0 : cur.x;
        y1    = wrap ? ({1'b0, cur.y} + {1'b0, cur.rh}) : {1'b0, cur.y};
        rh1   = wrap ? '0 : cur.rh;

        y_end     = {1'b0, y1} + (PAGE_W+2)'(h) + (PAGE_W+2)'(BORDER);
        new_layer = y_end > {2'b0, page};
        x2        = new_layer ? '0 : x1;
        y2        = new_layer ? '0 : y1;
        rh2       = new_layer ? '0 : rh1;
        layer2    = {1'b0, cur.layer} + (LAYER_W+1)'(new_layer);

        lim = {1'b0, layer2} + (LAYER_W+2)'(1);
        if (lim < (LAYER_W+2)'(2))
            lim = (LAYER_W+2)'(2);

        slot_h = PAGE_W'(h) + PAGE_W'(BORDER);

        res.tile_x     = x2[TILE_W-1:0];
        res.tile_y     = y2[TILE_W-1:0];
        res.layer      = layer2[LAYER_W] ? '1 : layer2[LAYER_W-1:0];
        res.flag       = (lim > {1'b0, max_layers}) || layer2[LAYER_W];
        res.next.x     = x2 + PAGE_W'(w) + PAGE_W'(BORDER);
        res.next.y     = y2[PAGE_W-1:0];
        res.next.rh    = (slot_h > rh2) ? slot_h : rh2;
        res.next.layer = layer2[LAYER_W-1:0];
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Testbench for mip_chain_shelf_packer_unit: directed and random texture words, a
// shelf-packing predictor in a scoreboard class, random output stalls and input gaps.
// Depends on mcsp_pkg and the mcsp_in_if, mcsp_out_if and mcsp_cfg_if interfaces.
module tb import mcsp_pkg::*;;

    localparam int LAYER_TOP = (1 << LAYER_W) - 1;

    typedef struct packed {
        mcsp_action_t        action;
        logic [SIDE_W-1:0]   width;
        logic [SIDE_W-1:0]   height;
        logic [LEVELS_W-1:0] levels;
    } texture_word_t;

    typedef struct packed {
        logic [TEXNUM_W-1:0] texture_number;
        logic [MIP_W-1:0]    mip;
        logic [TILE_W-1:0]   tile_x;
        logic [TILE_W-1:0]   tile_y;
        logic [TILE_W-1:0]   tile_width;
        logic [TILE_W-1:0]   tile_height;
        logic [LAYER_W-1:0]  layer;
        logic [1:0]          status;
        logic                last;
    } tile_word_t;

    class atlas_scoreboard;
        logic [PAGE_W-1:0]   page_size;
        logic [LIMIT_W-1:0]  max_layers;
        logic [PAGE_W-1:0]   cur_x;
        logic [PAGE_W-1:0]   cur_y;
        logic [PAGE_W-1:0]   row_h;
        logic [LAYER_W-1:0]  cur_layer;
        logic [TEXNUM_W-1:0] tex_count;
        tile_word_t          expected_tiles[$];
        int                  mismatches;

        function new();
            page_size  = PAGE_W'(MIN_PAGE);
            max_layers = LIMIT_W'(256);
            cur_x      = '0;
            cur_y      = '0;
            row_h      = '0;
            cur_layer  = '0;
            tex_count  = '0;
            mismatches = 0;
        endfunction

        function void write_reg(mcsp_reg_idx_t idx, logic [PAGE_W-1:0] data);
            case (idx)
                REG_PAGE_SIZE:  page_size = data;
                REG_MAX_LAYERS: max_layers = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function void queue_tile(tile_word_t r);
            expected_tiles = {expected_tiles, r};
        endfunction

        function void place_texture(texture_word_t t);
            int unsigned page, w, h, x, y, rh, lay, lim, count, bigger;
            tile_word_t  r;
            if (t.action == ACT_START)
            begin
                cur_x     = '0;
                cur_y     = '0;
                row_h     = '0;
                cur_layer = '0;
                tex_count = '0;
                return;
            end
            page = page_size;
            if (page < MIN_PAGE)
                page = MIN_PAGE;
            if (page > MAX_PAGE)
                page = MAX_PAGE;
            r = '0;
            r.texture_number = tex_count;
            tex_count++;
            r.layer = cur_layer;
            r.last  = 1'b1;
            if (t.width > MAX_SIDE || t.height > MAX_SIDE)
            begin
                r.status = ST_SIDE_LARGE;
                queue_tile(r);
                return;
            end
            bigger = (t.width > t.height) ? t.width : t.height;
            if (bigger + BORDER > page)
            begin
                r.status = ST_PAGE_LARGE;
                queue_tile(r);
                return;
            end
            count = t.levels + 1;
            if (count > MAX_MIPS)
                count = MAX_MIPS;
            for (int m = 0; m < count; m++)
            begin
                w   = t.width >> m;
                h   = t.height >> m;
                x   = cur_x;
                y   = cur_y;
                rh  = row_h;
                lay = cur_layer;
                if (w < 1)
                    w = 1;
                if (h < 1)
                    h = 1;
                if (x + w + BORDER > page)
                begin
                    x  = 0;
                    y  = y + rh;
                    rh = 0;
                end
                if (y + h + BORDER > page)
                begin
                    x   = 0;
                    y   = 0;
                    rh  = 0;
                    lay = lay + 1;
                end
                lim = (lay + 1 < 2) ? 2 : lay + 1;
                r.mip         = MIP_W'(m);
                r.tile_x      = TILE_W'(x);
                r.tile_y      = TILE_W'(y);
                r.tile_width  = TILE_W'(w);
                r.tile_height = TILE_W'(h);
                if (lim > max_layers || lay > LAYER_TOP)
                begin
                    r.layer  = LAYER_W'((lay > LAYER_TOP) ? LAYER_TOP : lay);
                    r.status = ST_LAYER_LIM;
                    r.last   = 1'b1;
                    queue_tile(r);
                    return;
                end
                r.layer  = LAYER_W'(lay);
                r.status = ST_OK;
                r.last   = (m + 1 == count);
                queue_tile(r);
                x = x + w + BORDER;
                if (h + BORDER > rh)
                    rh = h + BORDER;
                cur_x     = PAGE_W'(x);
                cur_y     = PAGE_W'(y);
                row_h     = PAGE_W'(rh);
                cur_layer = LAYER_W'(lay);
            end
        endfunction

        function void report(string what, tile_word_t exp, tile_word_t got);
            mismatches++;
            if (mismatches <= 10)
                $display({"%s: exp tex %0d mip %0d xy %0d,%0d size %0dx%0d layer %0d ",
                          "st %0d last %0d | got tex %0d mip %0d xy %0d,%0d size %0dx%0d ",
                          "layer %0d st %0d last %0d"},
                         what, exp.texture_number, exp.mip, exp.tile_x, exp.tile_y,
                         exp.tile_width, exp.tile_height, exp.layer, exp.status, exp.last,
                         got.texture_number, got.mip, got.tile_x, got.tile_y,
                         got.tile_width, got.tile_height, got.layer, got.status, got.last);
        endfunction

        function void check_tile(tile_word_t got);
            tile_word_t exp;
            if (expected_tiles.size() == 0)
            begin
                report("unexpected word", '0, got);
                return;
            end
            exp = expected_tiles.pop_front();
            if (got !== exp)
                report("mismatch", exp, got);
        endfunction

        function int pending();
            return expected_tiles.size();
        endfunction

        function void close();
            if (expected_tiles.size() != 0)
            begin
                $display("%0d tile words never arrived", expected_tiles.size());
                mismatches += expected_tiles.size();
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   page_eff;

    logic [PAGE_W-1:0] phase_page [8] = '{13'd4096, 13'd8191, 13'd100, 13'd1000,
                                         13'd512, 13'd0, 13'd2048, 13'd256};
    logic [PAGE_W-1:0] phase_layers [8] = '{13'd2048, 13'd2, 13'd3, 13'd0,
                                           13'd1, 13'd0, 13'd4095, 13'd256};

    atlas_scoreboard sb;

    mcsp_in_if  texture ();
    mcsp_out_if tile ();
    mcsp_cfg_if cfg ();

    mip_chain_shelf_packer_unit dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .texture (texture),
        .tile    (tile),
        .cfg     (cfg)
    );

    initial
        clk = 1'b0;

    always #4 clk = ~clk;

    always @(posedge clk)
    begin : tile_monitor
        tile_word_t got;
        if (rst_n && tile.valid && tile.ready)
        begin
            got.texture_number = tile.texture_number;
            got.mip            = tile.mip;
            got.tile_x         = tile.tile_x;
            got.tile_y         = tile.tile_y;
            got.tile_width     = tile.tile_width;
            got.tile_height    = tile.tile_height;
            got.layer          = tile.layer;
            got.status         = tile.status;
            got.last           = tile.last;
            sb.check_tile(got);
        end
    end

    // output back-pressure in random bursts
    initial
    begin : tile_stall
        int stall_left;
        stall_left = 0;
        tile.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                tile.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                tile.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            begin
                tile.ready <= 1'b0;
                stall_left = $urandom_range(3);
            end
            else
                tile.ready <= 1'b1;
        end
    end

    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    // entered and left at a falling edge
    task automatic send_texture(texture_word_t t);
        int gap;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 4);
            texture.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        texture.valid      <= 1'b1;
        texture.action     <= t.action;
        texture.tex_width  <= t.width;
        texture.tex_height <= t.height;
        texture.mip_levels <= t.levels;
        @(posedge clk);
        while (!texture.ready)
            @(posedge clk);
        sb.place_texture(t);
        @(negedge clk);
    endtask

    task automatic place(mcsp_action_t a, int w, int h, int lv);
        texture_word_t t;
        t.action = a;
        t.width  = SIDE_W'(w);
        t.height = SIDE_W'(h);
        t.levels = LEVELS_W'(lv);
        send_texture(t);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        texture.valid <= 1'b0;
        while (sb.pending() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic configure(logic [PAGE_W-1:0] page, logic [PAGE_W-1:0] layers);
        mcsp_reg_idx_t     idx;
        logic [PAGE_W-1:0] data;
        for (int i = 0; i < 2; i++)
        begin
            if (i == 0)
            begin
                idx  = REG_PAGE_SIZE;
                data = page;
            end
            else
            begin
                idx  = REG_MAX_LAYERS;
                data = layers;
            end
            cfg.valid <= 1'b1;
            cfg.index <= idx;
            cfg.data  <= data;
            @(posedge clk);
            while (!cfg.ready)
                @(posedge clk);
            sb.write_reg(idx, data);
            @(negedge clk);
        end
        cfg.valid <= 1'b0;
        page_eff = page;
        if (page_eff < MIN_PAGE)
            page_eff = MIN_PAGE;
        if (page_eff > MAX_PAGE)
            page_eff = MAX_PAGE;
    endtask

    function automatic texture_word_t random_texture();
        texture_word_t t;
        int            sel;
        t.action = ($urandom_range(99) < 4) ? ACT_START : ACT_PLACE;
        t.levels = LEVELS_W'(($urandom_range(3) == 0) ? $urandom_range(255) :
                                                        $urandom_range(15));
        sel = $urandom_range(99);
        if (sel < 8)
        begin
            t.width  = SIDE_W'($urandom_range(8191));
            t.height = SIDE_W'($urandom_range(8191));
        end
        else if (sel < 18)
        begin
            t.width  = SIDE_W'($urandom_range(page_eff - 6, page_eff - 1));
            t.height = SIDE_W'($urandom_range(page_eff - 1));
            if ($urandom_range(1))
                {t.width, t.height} = {t.height, t.width};
        end
        else
        begin
            t.width  = SIDE_W'($urandom_range(page_eff / 8));
            t.height = SIDE_W'($urandom_range(page_eff / 8));
        end
        return t;
    endfunction

    initial
    begin
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] layers;
        sb = new();
        rst_n              = 1'b0;
        idle_pct           = 30;
        page_eff           = MIN_PAGE;
        texture.valid      = 1'b0;
        texture.action     = ACT_START;
        texture.tex_width  = '0;
        texture.tex_height = '0;
        texture.mip_levels = '0;
        cfg.valid          = 1'b0;
        cfg.index          = REG_PAGE_SIZE;
        cfg.data           = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: page 256, layer limit 256
        place(ACT_START, 8191, 8191, 255);
        place(ACT_PLACE, 0, 0, 0);
        place(ACT_PLACE, 8191, 8191, 255);
        place(ACT_PLACE, 4095, 0, 3);
        place(ACT_PLACE, 0, 4095, 3);
        place(ACT_PLACE, 255, 3, 0);
        place(ACT_PLACE, 3, 255, 0);
        place(ACT_PLACE, 4094, 4094, 0);
        place(ACT_PLACE, 254, 254, 255);
        repeat (4) place(ACT_PLACE, 100, 60, 3);
        place(ACT_PLACE, 1, 8, 15);
        place(ACT_START, 0, 0, 0);
        place(ACT_PLACE, 7, 7, 20);
        drain();

        // largest page, tight layer limit
        configure(13'd4096, 13'd2);
        place(ACT_PLACE, 4094, 4094, 255);
        place(ACT_PLACE, 4094, 4094, 1);
        place(ACT_PLACE, 0, 0, 0);
        drain();

        // one tile per layer until the layer limit trips
        configure(13'd0, 13'd40);
        place(ACT_START, 0, 0, 0);
        repeat (60)
            place(ACT_PLACE, $urandom_range(128, 254), $urandom_range(128, 254), 0);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            page   = phase_page[p];
            layers = phase_layers[p];
            if (p == 5)
            begin
                page   = PAGE_W'(MIN_PAGE) << $urandom_range(4);
                layers = PAGE_W'($urandom_range(2, 2048));
            end
            idle_pct = (p == 7) ? 0 : ((p % 3 == 1) ? 0 : ((p % 3 == 0) ? 30 : 60));
            configure(page, layers);
            place(ACT_START, 0, 0, 0);
            repeat (40)
                send_texture(random_texture());
            drain();
        end

        sb.close();
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/mcsp_pkg.sv
hw/rtl/mcsp_in_if.sv
hw/rtl/mcsp_out_if.sv
hw/rtl/mcsp_cfg_if.sv
hw/rtl/mcsp_cfg_regs.sv
hw/rtl/mcsp_tile_unit.sv
hw/rtl/mip_chain_shelf_packer_unit.sv
test/tb.sv
